@@ rtl/vpts_pkg.sv @@
`default_nettype none
package vpts_pkg;

    localparam int LANE_W    = 16;
    localparam int ROT_FRAC  = 14;
    localparam int PLANE_SH  = 28;
    localparam int PQ_W      = 33;
    localparam int D_W       = 34;
    localparam int RP_W      = 50;
    localparam int N_W       = 54;
    localparam int WF_W      = 17;
    localparam int Q_BITS    = 47;
    localparam int QV_W      = 48;
    localparam int AX_W      = 49;
    localparam int PX_W      = 66;
    localparam int VP_SH     = 29;
    localparam int CFG_IDX_W = 3;

    localparam logic [Q_BITS-1:0] Q_LIMIT = {1'b1, {(Q_BITS-1){1'b0}}};

    localparam logic [47:0] PROJ_SCALE_RST  = 48'h4000_4000_4000;
    localparam logic [47:0] PROJ_OFFSET_RST = 48'h0;
    localparam logic [47:0] ROT_ROW_0_RST   = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_ROW_1_RST   = 48'h0000_4000_0000;
    localparam logic [63:0] PIVOT_RST       = 64'h0;
    localparam logic [47:0] PLANE_RST       = 48'h0;
    localparam logic [31:0] SCREEN_RST      = 32'h0384_0514;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROJ_SCALE  = 3'd0,
        REG_PROJ_OFFSET = 3'd1,
        REG_ROT_ROW_0   = 3'd2,
        REG_ROT_ROW_1   = 3'd3,
        REG_ROT_ROW_2   = 3'd4,
        REG_PIVOT       = 3'd5,
        REG_PLANE       = 3'd6,
        REG_SCREEN      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                   vld;
        logic signed [N_W-1:0]  nx;
        logic signed [N_W-1:0]  ny;
        logic signed [WF_W-1:0] wf;
    } xf_t;

    typedef struct packed {
        logic                   vld;
        logic                   zero;
        logic signed [QV_W-1:0] qx;
        logic signed [QV_W-1:0] qy;
    } dv_t;

    function automatic logic signed [LANE_W-1:0] lane16(input logic [63:0] r,
                                                        input int unsigned idx);
        return r[idx*LANE_W +: LANE_W];
    endfunction

endpackage
`default_nettype wire

@@ rtl/vertex_project_to_screen.sv @@
// Vertex projection to screen coordinates.
// Input channel s_*: one vertex (x, y, z, w, signed Q8.8) per transfer.
// Output channel m_*: screen_x, screen_y (signed, saturated) and divide_error.
// Config channel cfg_*: index 0..7 selects the register, cfg_ready is always
// high; write only while the pipeline is empty.
// The pipeline has 3 transform stages (projection multiplies, rotation
// multiplies, accumulate), 49 divider stages (sign/magnitude, range check,
// then one quotient bit per stage for 47 bits) and 3 viewport stages
// (offset, scale multiply, truncate and saturate, which is the output register).
// Throughput is one vertex per cycle while the receiver is not stalling.
// All stages advance together whenever the output register is empty or its
// transfer completes; while the receiver stalls, the whole pipe holds and
// s_ready drops. No item is lost or duplicated.
// Reset clears all valid bits and loads default registers: unit scales,
// identity rotation, zero pivot and plane, 1300x900 screen.
// Row 2 of the rotation only produces z, which is not used, so it is not stored.
// A zero final w gives divide_error with both positions zero.
`default_nettype none
module vertex_project_to_screen import vpts_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [LANE_W-1:0]     s_vert_x,
    input  wire logic signed [LANE_W-1:0]     s_vert_y,
    input  wire logic signed [LANE_W-1:0]     s_vert_z,
    input  wire logic signed [LANE_W-1:0]     s_vert_w,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [LANE_W-1:0]          m_screen_x,
    output logic signed [LANE_W-1:0]          m_screen_y,
    output logic                              m_divide_error,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [63:0]                  cfg_data
);

    logic [47:0] proj_scale_reg, proj_offset_reg, rot_row_0_reg, rot_row_1_reg;
    logic [47:0] plane_reg;
    logic [63:0] pivot_reg;
    logic [31:0] screen_reg;
    logic        en;
    xf_t         xf;
    dv_t         dv;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proj_scale_reg  <= PROJ_SCALE_RST;
            proj_offset_reg <= PROJ_OFFSET_RST;
            rot_row_0_reg   <= ROT_ROW_0_RST;
            rot_row_1_reg   <= ROT_ROW_1_RST;
            pivot_reg       <= PIVOT_RST;
            plane_reg       <= PLANE_RST;
            screen_reg      <= SCREEN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PROJ_SCALE:  proj_scale_reg  <= cfg_data[47:0];
                REG_PROJ_OFFSET: proj_offset_reg <= cfg_data[47:0];
                REG_ROT_ROW_0:   rot_row_0_reg   <= cfg_data[47:0];
                REG_ROT_ROW_1:   rot_row_1_reg   <= cfg_data[47:0];
                REG_ROT_ROW_2:   ;
                REG_PIVOT:       pivot_reg       <= cfg_data;
                REG_PLANE:       plane_reg       <= cfg_data[47:0];
                REG_SCREEN:      screen_reg      <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    vpts_transform u_transform (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_vld       (s_valid),
        .vert_x       (s_vert_x),
        .vert_y       (s_vert_y),
        .vert_z       (s_vert_z),
        .vert_w       (s_vert_w),
        .proj_scale   (proj_scale_reg),
        .proj_offset  (proj_offset_reg),
        .rot_row_0    (rot_row_0_reg),
        .rot_row_1    (rot_row_1_reg),
        .pivot        (pivot_reg),
        .plane_offset (plane_reg),
        .xf           (xf)
    );

    vpts_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .xf      (xf),
        .dv      (dv)
    );

    vpts_viewport u_viewport (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .dv           (dv),
        .screen_size  (screen_reg),
        .out_vld      (m_valid),
        .screen_x     (m_screen_x),
        .screen_y     (m_screen_y),
        .divide_error (m_divide_error)
    );

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_error |-> m_screen_x == '0 && m_screen_y == '0)
        else $error("divide error with nonzero position");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x) && $stable(m_screen_y))
        else $error("result changed during stall");

endmodule
`default_nettype wire

@@ rtl/vpts_transform.sv @@
`default_nettype none
module vpts_transform import vpts_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_vld,
    input  wire logic signed [LANE_W-1:0] vert_x,
    input  wire logic signed [LANE_W-1:0] vert_y,
    input  wire logic signed [LANE_W-1:0] vert_z,
    input  wire logic signed [LANE_W-1:0] vert_w,
    input  wire logic [47:0]              proj_scale,
    input  wire logic [47:0]              proj_offset,
    input  wire logic [47:0]              rot_row_0,
    input  wire logic [47:0]              rot_row_1,
    input  wire logic [63:0]              pivot,
    input  wire logic [47:0]              plane_offset,
    output xf_t                           xf
);

    logic signed [LANE_W-1:0] v [4];
    logic signed [PQ_W-1:0]   p_next [3];
    logic signed [PQ_W-1:0]   q_next [3];
    logic signed [PQ_W-1:0]   p_reg [3];
    logic signed [PQ_W-1:0]   q_reg [3];
    logic signed [WF_W-1:0]   wf1_next, wf1_reg, wf2_reg, wf3_reg;
    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [D_W-1:0]    d [3];
    logic signed [RP_W-1:0]   r_next [2][3];
    logic signed [RP_W-1:0]   r_reg [2][3];
    logic signed [PQ_W-1:0]   q2_reg [2];
    logic [47:0]              rr [2];
    logic signed [N_W-1:0]    n_next [2];
    logic signed [N_W-1:0]    n_reg [2];

    assign v[0]  = vert_x;
    assign v[1]  = vert_y;
    assign v[2]  = vert_z;
    assign v[3]  = vert_w;
    assign rr[0] = rot_row_0;
    assign rr[1] = rot_row_1;

    // stage 1: orthographic map of vertex and pivot
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_next[i] = PQ_W'(lane16(proj_scale, i)) * PQ_W'(v[i])
                      + PQ_W'(lane16(proj_offset, i)) * PQ_W'(v[3]);
            q_next[i] = PQ_W'(lane16(proj_scale, i)) * PQ_W'(lane16(pivot, i))
                      + PQ_W'(lane16(proj_offset, i)) * PQ_W'(lane16(pivot, 3));
        end
        wf1_next = WF_W'(v[3]) + WF_W'(lane16(plane_offset, 2));
    end

    // stage 2: rotation products, x and y rows
    always_comb begin
        for (int j = 0; j < 3; j++)
            d[j] = D_W'(p_reg[j]) - D_W'(q_reg[j]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
                r_next[i][j] = RP_W'(lane16(rr[i], j)) * RP_W'(d[j]);
    end

    // stage 3: sum, pivot and plane added back
    always_comb begin
        for (int i = 0; i < 2; i++)
            n_next[i] = N_W'(r_reg[i][0]) + N_W'(r_reg[i][1]) + N_W'(r_reg[i][2])
                      + (N_W'(q2_reg[i]) <<< ROT_FRAC)
                      + (N_W'(lane16(plane_offset, i)) <<< PLANE_SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= p_next;
            q_reg   <= q_next;
            wf1_reg <= wf1_next;
            r_reg   <= r_next;
            q2_reg[0] <= q_reg[0];
            q2_reg[1] <= q_reg[1];
            wf2_reg <= wf1_reg;
            n_reg   <= n_next;
            wf3_reg <= wf2_reg;
        end
    end

    assign xf.vld = v3_reg;
    assign xf.nx  = n_reg[0];
    assign xf.ny  = n_reg[1];
    assign xf.wf  = wf3_reg;

endmodule
`default_nettype wire

@@ rtl/vpts_divider.sv @@
`default_nettype none
module vpts_divider import vpts_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire xf_t  xf,
    output dv_t       dv
);

    logic [N_W-1:0]    mag_next [2];
    logic [N_W-1:0]    a_mag_reg [2];
    logic              a_neg_reg [2];
    logic [WF_W-1:0]   a_dm_reg;
    logic              a_zero_reg, a_vld_reg;

    logic [N_W-1:0]    nm_next [Q_BITS+1][2];
    logic [N_W-1:0]    nm_reg  [Q_BITS+1][2];
    logic [WF_W-1:0]   rem_next [Q_BITS+1][2];
    logic [WF_W-1:0]   rem_reg  [Q_BITS+1][2];
    logic [Q_BITS-1:0] q_next [Q_BITS+1][2];
    logic [Q_BITS-1:0] q_reg  [Q_BITS+1][2];
    logic              ovf_next [Q_BITS+1][2];
    logic              ovf_reg  [Q_BITS+1][2];
    logic              neg_reg  [Q_BITS+1][2];
    logic [WF_W-1:0]   dm_reg   [Q_BITS+1];
    logic              zero_reg [Q_BITS+1];
    logic              vld_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] qm [2];
    logic signed [QV_W-1:0] qs [2];

    always_comb begin
        mag_next[0] = xf.nx[N_W-1] ? N_W'(-xf.nx) : N_W'(xf.nx);
        mag_next[1] = xf.ny[N_W-1] ? N_W'(-xf.ny) : N_W'(xf.ny);
    end

    // one quotient bit per stage, restoring
    always_comb begin
        logic [WF_W:0] t;
        logic          ge;
        t  = '0;
        ge = 1'b0;
        for (int i = 0; i < 2; i++) begin
            nm_next[0][i]  = a_mag_reg[i];
            ovf_next[0][i] = 64'(a_mag_reg[i]) >= {a_dm_reg, {Q_BITS{1'b0}}};
            rem_next[0][i] = WF_W'(a_mag_reg[i] >> Q_BITS);
            q_next[0][i]   = '0;
        end
        for (int k = 1; k <= Q_BITS; k++) begin
            for (int i = 0; i < 2; i++) begin
                t  = {rem_reg[k-1][i], nm_reg[k-1][i][Q_BITS-k]};
                ge = t >= {1'b0, dm_reg[k-1]};
                nm_next[k][i]  = nm_reg[k-1][i];
                ovf_next[k][i] = ovf_reg[k-1][i];
                rem_next[k][i] = ge ? WF_W'(t - {1'b0, dm_reg[k-1]}) : WF_W'(t);
                q_next[k][i]   = q_reg[k-1][i];
                q_next[k][i][Q_BITS-k] = ge;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            for (int k = 0; k <= Q_BITS; k++)
                vld_reg[k] <= 1'b0;
        end else if (en) begin
            a_vld_reg  <= xf.vld;
            vld_reg[0] <= a_vld_reg;
            for (int k = 1; k <= Q_BITS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg    <= mag_next;
            a_neg_reg[0] <= xf.nx[N_W-1] ^ xf.wf[WF_W-1];
            a_neg_reg[1] <= xf.ny[N_W-1] ^ xf.wf[WF_W-1];
            a_dm_reg     <= xf.wf[WF_W-1] ? WF_W'(-xf.wf) : WF_W'(xf.wf);
            a_zero_reg   <= (xf.wf == '0);
            nm_reg   <= nm_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            ovf_reg  <= ovf_next;
            neg_reg[0]  <= a_neg_reg;
            dm_reg[0]   <= a_dm_reg;
            zero_reg[0] <= a_zero_reg;
            for (int k = 1; k <= Q_BITS; k++) begin
                neg_reg[k]  <= neg_reg[k-1];
                dm_reg[k]   <= dm_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            qm[i] = (ovf_reg[Q_BITS][i] || q_reg[Q_BITS][i] > Q_LIMIT)
                  ? Q_LIMIT : q_reg[Q_BITS][i];
            qs[i] = neg_reg[Q_BITS][i] ? -QV_W'(qm[i]) : QV_W'(qm[i]);
        end
    end

    assign dv.vld  = vld_reg[Q_BITS];
    assign dv.zero = zero_reg[Q_BITS];
    assign dv.qx   = qs[0];
    assign dv.qy   = qs[1];

endmodule
`default_nettype wire

@@ rtl/vpts_viewport.sv @@
`default_nettype none
module vpts_viewport import vpts_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire dv_t                      dv,
    input  wire logic [31:0]              screen_size,
    output logic                          out_vld,
    output logic signed [LANE_W-1:0]      screen_x,
    output logic signed [LANE_W-1:0]      screen_y,
    output logic                          divide_error
);

    logic signed [AX_W-1:0]   a_next [2];
    logic signed [AX_W-1:0]   a_reg [2];
    logic signed [PX_W-1:0]   p_next [2];
    logic signed [PX_W-1:0]   p_reg [2];
    logic signed [PX_W-1:0]   adj [2];
    logic signed [PX_W-1:0]   sh [2];
    logic [LANE_W-1:0]        s_next [2];
    logic [LANE_W-1:0]        dim [2];
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     z1_reg, z2_reg, z3_reg;
    logic [LANE_W-1:0]        sx_reg, sy_reg;

    assign dim[0] = screen_size[15:0];
    assign dim[1] = screen_size[31:16];

    always_comb begin
        a_next[0] = AX_W'(dv.qx) + (AX_W'(1) <<< PLANE_SH);
        a_next[1] = (AX_W'(1) <<< PLANE_SH) - AX_W'(dv.qy);
        for (int i = 0; i < 2; i++)
            p_next[i] = PX_W'($signed({1'b0, dim[i]})) * PX_W'(a_reg[i]);
    end

    // truncate toward zero, then saturate
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            adj[i] = p_reg[i][PX_W-1] ? p_reg[i] + ((PX_W'(1) <<< VP_SH) - PX_W'(1))
                                      : p_reg[i];
            sh[i]  = adj[i] >>> VP_SH;
            if (z2_reg)
                s_next[i] = '0;
            else if (!sh[i][PX_W-1] && (|sh[i][PX_W-2:LANE_W-1]))
                s_next[i] = {1'b0, {(LANE_W-1){1'b1}}};
            else if (sh[i][PX_W-1] && !(&sh[i][PX_W-2:LANE_W-1]))
                s_next[i] = {1'b1, {(LANE_W-1){1'b0}}};
            else
                s_next[i] = sh[i][LANE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= dv.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= a_next;
            z1_reg <= dv.zero;
            p_reg  <= p_next;
            z2_reg <= z1_reg;
            sx_reg <= s_next[0];
            sy_reg <= s_next[1];
            z3_reg <= z2_reg;
        end
    end

    assign out_vld      = v3_reg;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;
    assign divide_error = z3_reg;

endmodule
`default_nettype wire

@@ verif/vertex_project_to_screen_test.sv @@
`timescale 1ns / 1ps
module vertex_project_to_screen_test;
    import vpts_pkg::*;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               err;
    } screen_pt_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [LANE_W-1:0] s_vert_x;
    logic signed [LANE_W-1:0] s_vert_y;
    logic signed [LANE_W-1:0] s_vert_z;
    logic signed [LANE_W-1:0] s_vert_w;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [LANE_W-1:0] m_screen_x;
    logic signed [LANE_W-1:0] m_screen_y;
    logic                     m_divide_error;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [63:0]              cfg_data;

    vertex_project_to_screen dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vert_x(s_vert_x), .s_vert_y(s_vert_y),
        .s_vert_z(s_vert_z), .s_vert_w(s_vert_w),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_screen_x(m_screen_x), .m_screen_y(m_screen_y),
        .m_divide_error(m_divide_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [63:0] proj_regs [8];
    screen_pt_t  pending_pts [$];
    int          fail_count = 0;
    bit          idle_on = 1;
    int          long_hold = 0;
    int          quiet_cycles = 0;

    initial aclk = 0;
    always #10 aclk = ~aclk;

    function automatic longint lane_of(logic [63:0] r, int idx);
        logic signed [15:0] l;
        l = r[idx*16 +: 16];
        return longint'(l);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic screen_pt_t project(logic signed [15:0] vx, logic signed [15:0] vy,
                                           logic signed [15:0] vz, logic signed [15:0] vw);
        longint v[4], q[3], d[3], n[3];
        longint s, o, acc, wfin, xq, yq, width, height;
        screen_pt_t pt;
        v[0] = vx; v[1] = vy; v[2] = vz; v[3] = vw;
        for (int i = 0; i < 3; i++) begin
            s = lane_of(proj_regs[REG_PROJ_SCALE], i);
            o = lane_of(proj_regs[REG_PROJ_OFFSET], i);
            q[i] = s * lane_of(proj_regs[REG_PIVOT], i) + o * lane_of(proj_regs[REG_PIVOT], 3);
            d[i] = s * v[i] + o * v[3] - q[i];
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += lane_of(proj_regs[REG_ROT_ROW_0 + i], j) * d[j];
            n[i] = acc + q[i] * (64'sd1 <<< 14) + lane_of(proj_regs[REG_PLANE], i) * (64'sd1 <<< 28);
        end
        wfin = v[3] + lane_of(proj_regs[REG_PLANE], 2);
        if (wfin == 0) begin
            pt.sx = 0; pt.sy = 0; pt.err = 1;
            return pt;
        end
        xq = n[0] / wfin;
        yq = n[1] / wfin;
        if (xq > (64'sd1 <<< 46)) xq = 64'sd1 <<< 46;
        if (xq < -(64'sd1 <<< 46)) xq = -(64'sd1 <<< 46);
        if (yq > (64'sd1 <<< 46)) yq = 64'sd1 <<< 46;
        if (yq < -(64'sd1 <<< 46)) yq = -(64'sd1 <<< 46);
        width = longint'(proj_regs[REG_SCREEN][15:0]);
        height = longint'(proj_regs[REG_SCREEN][31:16]);
        pt.sx = clip16(width * (xq + (64'sd1 <<< 28)) / (64'sd1 <<< 29));
        pt.sy = clip16(height * ((64'sd1 <<< 28) - yq) / (64'sd1 <<< 29));
        pt.err = 0;
        return pt;
    endfunction

    // result checker
    always @(posedge aclk) begin
        screen_pt_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pts.size() == 0) begin
                $display("%0t: unexpected transfer x=%0d y=%0d err=%0b", $time,
                         m_screen_x, m_screen_y, m_divide_error);
                fail_count++;
            end else begin
                e = pending_pts.pop_front();
                if (m_screen_x !== e.sx) begin
                    $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, m_screen_x);
                    fail_count++;
                end
                if (m_screen_y !== e.sy) begin
                    $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, m_screen_y);
                    fail_count++;
                end
                if (m_divide_error !== e.err) begin
                    $display("%0t: divide_error expected %0b actual %0b", $time, e.err,
                             m_divide_error);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (long_hold > 0) begin
                m_ready <= 0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(0, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("vertex_project_to_screen regression: fail");
            $finish;
        end
    end

    task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz, logic [15:0] vw);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1;
        s_vert_x <= vx; s_vert_y <= vy; s_vert_z <= vz; s_vert_w <= vw;
        do @(posedge aclk); while (!s_ready);
        pending_pts.push_back(project(vx, vy, vz, vw));
    endtask

    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (pending_pts.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SCREEN) proj_regs[idx] = {32'h0, data[31:0]};
        else if (idx == REG_PIVOT) proj_regs[idx] = data;
        else proj_regs[idx] = {16'h0, data[47:0]};
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1024)) - 512);
            2: return 16'($signed($urandom_range(0, 8192)) - 4096);
            default: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'($urandom)};
        endcase
    endfunction

    task automatic send_random(int count);
        logic [15:0] w;
        for (int i = 0; i < count; i++) begin
            w = $urandom_range(0, 7) == 0 ? 16'(-lane_of(proj_regs[REG_PLANE], 2))
                                          : rand_coord();
            send_vertex(rand_coord(), rand_coord(), rand_coord(), w);
        end
    endtask

    task automatic test_default_extremes();
        logic [15:0] ext [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        foreach (ext[i]) send_vertex(ext[i], ext[3-i], ext[i], 16'h0100);
        send_vertex(16'h0080, 16'hff80, 16'h0000, 16'h0100);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h7fff, 16'h8000, 16'h1234, 16'h0001);
        send_vertex(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_vertex(16'h0100, 16'h0100, 16'h0100, 16'h7fff);
        drain();
    endtask

    task automatic test_plane_zero_w();
        write_reg(REG_PLANE, 48'h0200_0040_ffc0);
        send_vertex(16'h0100, 16'h0100, 16'h0100, 16'h0200);
        send_vertex(16'h0100, 16'h0100, 16'h0100, 16'h0201);
        send_vertex(16'h8000, 16'h7fff, 16'h0000, 16'h01ff);
        drain();
    endtask

    task automatic test_zero_screen();
        write_reg(REG_SCREEN, 32'h0000_0000);
        send_vertex(16'h0040, 16'h0040, 16'h0000, 16'h0100);
        send_vertex(16'h7fff, 16'h8000, 16'h0000, 16'h0001);
        drain();
        write_reg(REG_SCREEN, 32'hffff_ffff);
        send_vertex(16'h0040, 16'hffc0, 16'h0000, 16'h0100);
        send_vertex(16'h7fff, 16'h8000, 16'h0000, 16'h0001);
        drain();
    endtask

    task automatic test_register_sweep();
        for (int k = 0; k < 8; k++) begin
            for (int r = REG_PROJ_SCALE; r <= REG_SCREEN; r++) begin
                if (k == 0) write_reg(cfg_idx_t'(r), 64'h0);
                else if (k == 1) write_reg(cfg_idx_t'(r), {64{1'b1}});
                else if (r == REG_SCREEN) write_reg(cfg_idx_t'(r),
                    {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000))});
                else if (k < 5) write_reg(cfg_idx_t'(r), rand64());
                else write_reg(cfg_idx_t'(r), rand64() & 64'h0fff_0fff_0fff_0fff
                                               | 64'h1000_1000_1000_1000);
            end
            send_random(45);
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_PROJ_SCALE, 48'h4000_4000_4000);
        write_reg(REG_SCREEN, 32'h0384_0514);
        long_hold = 300;
        idle_on = 0;
        send_random(100);
        idle_on = 1;
        drain();
    endtask

    task automatic test_random_stream();
        for (int k = 0; k < 3; k++) begin
            write_reg(REG_ROT_ROW_0, rand64());
            write_reg(REG_ROT_ROW_1, rand64());
            write_reg(REG_PIVOT, rand64() & 64'h03ff_03ff_03ff_03ff);
            write_reg(REG_PLANE, rand64());
            send_random(40);
            drain();
        end
        idle_on = 0;
        send_random(60);
        drain();
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_vert_x = 0; s_vert_y = 0; s_vert_z = 0; s_vert_w = 0;
        cfg_valid = 0; cfg_index = REG_PROJ_SCALE; cfg_data = 0;
        proj_regs[0] = 64'h4000_4000_4000;
        proj_regs[1] = 0;
        proj_regs[2] = 64'h0000_0000_4000;
        proj_regs[3] = 64'h0000_4000_0000;
        proj_regs[4] = 64'h4000_0000_0000;
        proj_regs[5] = 0;
        proj_regs[6] = 0;
        proj_regs[7] = 64'h0384_0514;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_default_extremes();
        test_plane_zero_w();
        test_zero_screen();
        test_register_sweep();
        test_backpressure();
        test_random_stream();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending_pts.size() == 0)
            $display("vertex_project_to_screen regression: pass");
        else
            $display("vertex_project_to_screen regression: fail");
        $finish;
    end
endmodule
